// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes of the circular deque: request and response
// transactions, command and status codes, controller commands.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// command codes carried in req.cmd; unused codes act as peek
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_REAR   = 3'd3;
	localparam logic [2:0] CMD_PEEK       = 3'd4;

	// status codes carried in rsp.status
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// word reported where there is nothing to report
	localparam logic signed [31:0] WORD_NONE = 32'shFFFF_FFFF;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic signed [31:0] front_value;
		logic signed [31:0] rear_value;
		logic [3:0]         count;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;   // capture the request
		logic update;  // move pointers, write or read the popped entry
		logic fetch;   // read front and rear entries
		logic load;    // load the response register
	} ctl_t;

endpackage

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer of the circular deque: steps one request through update,
// fetch and response load, and holds off new requests meanwhile.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic          out_free,
	output cdq_pkg::ctl_t ctl
);
	import cdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_FETCH,
		S_DONE
	} state_t;

	state_t state_q;
	logic   req_stall_q;

	assign req_stall = req_stall_q;

	// decode datapath commands from the state
	always_comb begin
		ctl.latch  = (state_q == S_IDLE) && req_valid && !req_stall_q;
		ctl.update = (state_q == S_UPDATE);
		ctl.fetch  = (state_q == S_FETCH);
		ctl.load   = (state_q == S_DONE) && out_free;
	end

	// advance state; stall requests from acceptance until the response loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && !req_stall_q) begin
						state_q     <= S_UPDATE;
						req_stall_q <= 1'b1;
					end
				end
				S_UPDATE: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						req_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					req_stall_q <= 1'b0;
				end
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_UPDATE))
		else $error("accepted transaction did not start an update");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> req_stall)
		else $error("request not stalled while a transaction is in work");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> !ctl.load && (state_q == S_IDLE))
		else $error("response loaded twice for one transaction");

endmodule

// ===== rtl/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// cdq_datapath
// Storage, pointers and fill count of the circular deque, plus the response
// register. Acts on commands from the controller and on the response handshake.
// ----------------------------------------------------------------------------
module cdq_datapath #(
	parameter int DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cdq_pkg::req_t req,
	input  cdq_pkg::ctl_t ctl,
	output logic          out_free,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cdq_pkg::rsp_t rsp
);
	import cdq_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FILL_MAX = CW'(DEPTH);

	logic [31:0]   mem [DEPTH];

	logic [2:0]         cmd_q;
	logic signed [31:0] data_q;
	logic [PW-1:0]      head_q;
	logic [PW-1:0]      tail_q;
	logic [CW-1:0]      fill_q;
	logic [1:0]         status_q;
	logic               pop_ok_q;
	logic [31:0]        rd_a_q;
	logic [31:0]        rd_b_q;
	logic signed [31:0] popped_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic          is_push;
	logic          is_pop;
	logic          empty;
	logic          full;
	logic [PW-1:0] head_back;
	logic [PW-1:0] head_fwd;
	logic [PW-1:0] tail_back;
	logic [PW-1:0] tail_fwd;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [PW-1:0] rd_addr_a;

	// decode the held command and the occupancy
	always_comb begin
		is_push   = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_REAR);
		is_pop    = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_REAR);
		empty     = (fill_q == '0);
		full      = (fill_q == FILL_MAX);
		head_back = (head_q == '0) ? PTR_LAST : head_q - PW'(1);
		head_fwd  = (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
		tail_back = (tail_q == '0) ? PTR_LAST : tail_q - PW'(1);
		tail_fwd  = (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
	end

	// pick the write slot of a push and the read slot of a pop
	always_comb begin
		wr_en   = ctl.update && is_push && !full;
		wr_addr = '0;
		if (!empty) begin
			wr_addr = (cmd_q == CMD_PUSH_FRONT) ? head_back : tail_fwd;
		end
		rd_addr_a = head_q;
		if (ctl.update && (cmd_q == CMD_POP_REAR)) begin
			rd_addr_a = tail_q;
		end
	end

	// store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= data_q;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[tail_q];
	end

	// capture the transaction
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= req.cmd;
			data_q <= req.data_in;
		end
	end

	// update pointers, fill count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			status_q <= ST_DONE;
			pop_ok_q <= 1'b0;
		end else if (ctl.update) begin
			status_q <= ST_DONE;
			pop_ok_q <= 1'b0;
			if (is_push) begin
				if (full) begin
					status_q <= ST_FULL;
				end else begin
					if (empty) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (cmd_q == CMD_PUSH_FRONT) begin
						head_q <= head_back;
					end else begin
						tail_q <= tail_fwd;
					end
					fill_q <= fill_q + CW'(1);
				end
			end else if (is_pop) begin
				if (empty) begin
					status_q <= ST_EMPTY;
				end else begin
					pop_ok_q <= 1'b1;
					if (fill_q == CW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (cmd_q == CMD_POP_FRONT) begin
						head_q <= head_fwd;
					end else begin
						tail_q <= tail_back;
					end
					fill_q <= fill_q - CW'(1);
				end
			end
		end
	end

	// hold the popped word before the read ports move on to front and rear
	always_ff @(posedge clk) begin
		if (ctl.fetch) begin
			popped_q <= pop_ok_q ? signed'(rd_a_q) : WORD_NONE;
		end
	end

	// response register
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rsp_q.status       <= status_q;
			rsp_q.popped_value <= popped_q;
			rsp_q.front_value  <= empty ? WORD_NONE : signed'(rd_a_q);
			rsp_q.rear_value   <= empty ? WORD_NONE : signed'(rd_b_q);
			rsp_q.count        <= 4'(fill_q);
			rsp_q.is_empty     <= empty;
			rsp_q.is_full      <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= FILL_MAX) && (head_q <= PTR_LAST) && (tail_q <= PTR_LAST))
		else $error("fill count or pointer out of range");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (head_q == '0) && (tail_q == '0))
		else $error("pointers not home while deque is empty");

	a_rsp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.is_empty && rsp_q.is_full))
		else $error("response reports empty and full together");

endmodule

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of 32-bit words in a circular store of DEPTH entries.
// Push and pop at either end, or peek; every request gives one response.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   cmd, data_in
//   rsp      out        rsp_valid / rsp_stall   status, popped_value,
//                                               front_value, rear_value,
//                                               count, is_empty, is_full
//
// A request steps from acceptance to its response being loaded through update
// with the popped-word read, front/rear read and load; the store's read ports
// are registered. One request is in work at a time and the next is accepted
// once the controller is back in idle after the load.
// A stalled earlier response delays the load, and with it the next acceptance.
// The next request is taken while the last response still waits downstream.
// Reset clears pointers and fill count; the store is not cleared.
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cdq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cdq_pkg::rsp_t rsp
);
	import cdq_pkg::*;

	ctl_t ctl;
	logic out_free;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	cdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.out_free  (out_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== sim/circular_deque_test.sv =====
// ----------------------------------------------------------------------------
// circular_deque_test
// Self-checking testbench of the circular deque. Directed commands cover the
// empty and full edges, pushes into an empty deque, pops of the last word and
// the unused command codes. Random traffic follows with fill and drain runs
// and mixed commands. A local deque model predicts every response, and each
// response is checked field by field with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module circular_deque_test;

	import cdq_pkg::*;

	localparam int DQ_DEPTH = 8;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	// local copy of the deque state
	logic signed [31:0] dq_words [DQ_DEPTH];
	int                 dq_front;
	int                 dq_rear;
	int                 dq_held;

	rsp_t pending_rsp [$];

	bit send_idle;
	bit rsp_idle;
	int mismatches;
	int rsp_seen;
	int full_rejects;
	int empty_rejects;
	int full_hits;

	circular_deque #(.DEPTH(DQ_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// apply one command to the local deque and return its response
	function automatic rsp_t apply_deque_cmd(input req_t r);
		rsp_t o;
		o.status       = ST_DONE;
		o.popped_value = WORD_NONE;
		case (r.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (dq_held == DQ_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					if (dq_held == 0) begin
						dq_front = 0;
						dq_rear  = 0;
					end else if (r.cmd == CMD_PUSH_FRONT) begin
						dq_front = (dq_front == 0) ? DQ_DEPTH - 1 : dq_front - 1;
					end else begin
						dq_rear = (dq_rear == DQ_DEPTH - 1) ? 0 : dq_rear + 1;
					end
					dq_words[(r.cmd == CMD_PUSH_FRONT) ? dq_front : dq_rear] = r.data_in;
					dq_held++;
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (dq_held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.popped_value = dq_words[(r.cmd == CMD_POP_FRONT) ? dq_front : dq_rear];
					if (dq_held == 1) begin
						dq_front = 0;
						dq_rear  = 0;
					end else if (r.cmd == CMD_POP_FRONT) begin
						dq_front = (dq_front == DQ_DEPTH - 1) ? 0 : dq_front + 1;
					end else begin
						dq_rear = (dq_rear == 0) ? DQ_DEPTH - 1 : dq_rear - 1;
					end
					dq_held--;
				end
			end
			default: begin
			end
		endcase
		o.front_value = (dq_held == 0) ? WORD_NONE : dq_words[dq_front];
		o.rear_value  = (dq_held == 0) ? WORD_NONE : dq_words[dq_rear];
		o.count       = dq_held[3:0];
		o.is_empty    = (dq_held == 0);
		o.is_full     = (dq_held == DQ_DEPTH);
		return o;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_idle(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// choose which sides idle for the next stretch of traffic
	task automatic pick_pacing();
		int m;
		m = $urandom_range(0, 3);
		send_idle = m[0];
		rsp_idle  = m[1];
	endtask

	// random word, with the extremes now and then
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh0000_0000;
			3:       return 32'shFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// send one request transaction and record its expected response
	task automatic send_req(input logic [2:0] cmd, input logic signed [31:0] word);
		int   gap;
		bit   taken;
		req_t r;
		rsp_t e;
		r.cmd     = cmd;
		r.data_in = word;
		gap = pick_idle(send_idle);
		if (gap > 0) begin
			req_valid <= 1'b0;
			req       <= '0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do begin
			@(negedge clk);
			taken = !req_stall;
			if (taken) begin
				e = apply_deque_cmd(r);
				if (e.status == ST_FULL)
					full_rejects++;
				if (e.status == ST_EMPTY)
					empty_rejects++;
				if (e.is_full)
					full_hits++;
				pending_rsp.push_back(e);
			end
			@(posedge clk);
		end while (!taken);
	endtask

	// drive response stalls in bursts
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				stall_left = pick_idle(rsp_idle);
			end
		end
	end

	// check each response transaction against the oldest expectation
	initial begin
		rsp_t e;
		forever begin
			@(negedge clk);
			if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				rsp_seen++;
				if (pending_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response %0d arrived with none expected: %p", rsp_seen, rsp);
				end else begin
					e = pending_rsp.pop_front();
					if (rsp !== e) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("response %0d mismatch (expected / actual):", rsp_seen);
							$display("  status %0d / %0d  popped %0d / %0d  count %0d / %0d",
								e.status, rsp.status, e.popped_value, rsp.popped_value,
								e.count, rsp.count);
							$display("  front %0d / %0d  rear %0d / %0d  empty %b / %b  full %b / %b",
								e.front_value, rsp.front_value, e.rear_value, rsp.rear_value,
								e.is_empty, rsp.is_empty, e.is_full, rsp.is_full);
						end
					end
				end
			end
		end
	end

	// empty and full edges, extremes and unused codes
	task automatic test_directed();
		send_req(CMD_PEEK, 32'sd0);
		send_req(CMD_POP_FRONT, 32'sd0);
		send_req(CMD_POP_REAR, 32'sh7FFF_FFFF);
		send_req(CMD_PUSH_REAR, 32'sh7FFF_FFFF);
		send_req(CMD_POP_FRONT, 32'sd0);
		send_req(CMD_PUSH_FRONT, 32'sh8000_0000);
		send_req(CMD_PUSH_FRONT, 32'sd0);
		send_req(CMD_PUSH_REAR, 32'shFFFF_FFFF);
		send_req(CMD_PUSH_FRONT, 32'sh5555_5555);
		send_req(CMD_PUSH_REAR, 32'shAAAA_AAAA);
		send_req(CMD_PUSH_FRONT, 32'sd1);
		send_req(CMD_PUSH_REAR, -32'sd2);
		send_req(CMD_PUSH_REAR, 32'sh7FFF_FFFF);
		send_req(CMD_PUSH_FRONT, 32'sd3);
		send_req(CMD_PUSH_REAR, 32'sd4);
		send_req(3'd5, 32'sd5);
		send_req(3'd6, 32'sd6);
		send_req(3'd7, 32'sd7);
		for (int i = 0; i < DQ_DEPTH; i++)
			send_req(i[0] ? CMD_POP_REAR : CMD_POP_FRONT, $urandom());
	endtask

	// fill toward full and often past it, then drain toward empty and often past it, from random ends
	task automatic test_fill_drain(input int rounds);
		for (int k = 0; k < rounds; k++) begin
			if (k % 3 == 0)
				pick_pacing();
			repeat ($urandom_range(DQ_DEPTH - 2, DQ_DEPTH + 3))
				send_req($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, pick_word());
			if ($urandom_range(0, 1))
				send_req(CMD_PEEK, $urandom());
			repeat ($urandom_range(DQ_DEPTH - 2, DQ_DEPTH + 3))
				send_req($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT, $urandom());
		end
	endtask

	// mixed commands with a drifting push bias, unused codes included
	task automatic test_mixed_traffic(input int items);
		int r;
		int push_bias;
		push_bias = 50;
		for (int i = 0; i < items; i++) begin
			if (i % 40 == 0) begin
				pick_pacing();
				push_bias = $urandom_range(25, 75);
			end
			r = $urandom_range(0, 99);
			if (r < push_bias)
				send_req($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, pick_word());
			else if (r < 92)
				send_req($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT, $urandom());
			else if (r < 96)
				send_req(CMD_PEEK, $urandom());
			else
				send_req(3'($urandom_range(5, 7)), $urandom());
		end
	endtask

	initial begin
		mismatches    = 0;
		rsp_seen      = 0;
		full_rejects  = 0;
		empty_rejects = 0;
		full_hits     = 0;
		send_idle     = 1'b0;
		rsp_idle      = 1'b0;
		dq_front      = 0;
		dq_rear       = 0;
		dq_held       = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_drain(14);
		test_mixed_traffic(290);

		// let the last responses drain
		req_valid <= 1'b0;
		req       <= '0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("%0d responses checked: %0d pushes refused full, %0d pops refused empty,",
			rsp_seen, full_rejects, empty_rejects);
		$display("%0d responses reporting a full deque, %0d mismatches",
			full_hits, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("** circular_deque: PASSED **");
		else
			$display("** circular_deque: FAILED **");
		$finish;
	end

	// stop a hung run
	initial begin
		#2000000;
		$display("timeout with %0d responses outstanding", pending_rsp.size());
		$display("** circular_deque: FAILED **");
		$finish;
	end

endmodule
